[rtl/lap_pkg.sv]
// ---------------------------------------------------------------------------
// lap_pkg
// Shared types, constants and kernel coefficients of the 3x3 Laplacian filter.
// ---------------------------------------------------------------------------
package lap_pkg;

  // default frame limits
  localparam int unsigned LAP_MAX_WIDTH  = 1024;
  localparam int unsigned LAP_MAX_HEIGHT = 1024;

  // field widths
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned RGB_W      = 3 * PIX_W;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned KSEL_W     = 2;
  localparam int unsigned SIZE_CFG_W = 11;
  localparam int unsigned ACC_W      = 13;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_SELECT = 2'd0,
    REG_IMAGE_WIDTH   = 2'd1,
    REG_IMAGE_HEIGHT  = 2'd2,
    REG_MAX_LEVEL     = 2'd3
  } lap_reg_e;

  // kernel coefficients, taps in raster order top-left first
  localparam logic signed [4:0] KERNEL_TAPS [4][9] = '{
    '{5'sd0,  -5'sd1, 5'sd0,  -5'sd1, 5'sd4,  -5'sd1, 5'sd0,  -5'sd1, 5'sd0},
    '{5'sd0,  5'sd1,  5'sd0,  5'sd1,  -5'sd4, 5'sd1,  5'sd0,  5'sd1,  5'sd0},
    '{-5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd8,  -5'sd1, -5'sd1, -5'sd1, -5'sd1},
    '{5'sd1,  5'sd1,  5'sd1,  5'sd1,  -5'sd8, 5'sd1,  5'sd1,  5'sd1,  5'sd1}
  };

  // image borders seen by the center pixel
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } lap_bound_t;

  // one window column, oldest row on top
  typedef struct packed {
    logic [RGB_W-1:0] top;
    logic [RGB_W-1:0] mid;
    logic [RGB_W-1:0] bot;
  } lap_col_t;

endpackage

[rtl/lap_in_if.sv]
// ---------------------------------------------------------------------------
// lap_in_if
// Pixel request channel: valid/ready with mode flag and RGB samples.
// ---------------------------------------------------------------------------
interface lap_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output mode, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input mode, input red, input green, input blue,
                  output ready);
endinterface

[rtl/lap_out_if.sv]
// ---------------------------------------------------------------------------
// lap_out_if
// Result request channel: valid/ready with filtered RGB and frame marker.
// ---------------------------------------------------------------------------
interface lap_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_last;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output frame_last, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input frame_last, output ready);
endinterface

[rtl/lap_ram.sv]
// ---------------------------------------------------------------------------
// lap_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module lap_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port, read returns the old word on a same-address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/lap_conv.sv]
// ---------------------------------------------------------------------------
// lap_conv
// One channel of the 3x3 Laplacian: masked kernel sum and output clamp.
// ---------------------------------------------------------------------------
module lap_conv (
  input  logic [7:0]          taps_i [9],
  input  lap_pkg::lap_bound_t bound_i,
  input  logic [1:0]          ksel_i,
  input  logic [7:0]          max_level_i,
  output logic [7:0]          level_o
);
  import lap_pkg::*;

  logic [2:0]              row_ok;
  logic [2:0]              col_ok;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] coef;
  logic signed [ACC_W-1:0] smp;
  logic signed [ACC_W-1:0] limit;

  // neighbors outside the image drop out of the sum
  assign row_ok = {!bound_i.bottom, 1'b1, !bound_i.top};
  assign col_ok = {!bound_i.right, 1'b1, !bound_i.left};

  // kernel sum over the window
  always_comb begin
    acc  = '0;
    coef = '0;
    smp  = '0;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        coef = ACC_W'(KERNEL_TAPS[ksel_i][dr*3+dc]);
        smp  = signed'(ACC_W'(taps_i[dr*3+dc]));
        if (row_ok[dr] && col_ok[dc]) begin
          acc = acc + ACC_W'(coef * smp);
        end
      end
    end
  end

  // clamp to 0..max_level
  assign limit = signed'(ACC_W'(max_level_i));

  always_comb begin
    if (acc < 0) begin
      level_o = '0;
    end else if (acc > limit) begin
      level_o = max_level_i;
    end else begin
      level_o = acc[7:0];
    end
  end

endmodule

[rtl/laplacian_filter_3x3.sv]
// ---------------------------------------------------------------------------
// laplacian_filter_3x3
// Streaming per-channel 3x3 Laplacian on a raster RGB pixel stream.
// ---------------------------------------------------------------------------
// The block takes at most one request per clock and gives at most one result per
// request; with the result side ready it sustains one pixel per cycle. A
// request passes an input stage (line store read) and then a result register
// before its result leaves on the output channel.
// The result for center (r,c) comes with the request at raster position
// r*W+c+W+1; after the H*W pixels, send W+1 drain requests to flush the last
// row, after which the position counters restart. Width and height are
// sampled with the first request of a frame; kernel_select and max_level
// act at once. Both line stores share one MAX_WIDTH deep RAM of 48-bit
// words, read and written once per request at the column address; it needs
// no clearing pass after reset, since the first row's upper neighbors are
// never used.
// ---------------------------------------------------------------------------
module laplacian_filter_3x3 #(
  parameter int unsigned MAX_WIDTH  = lap_pkg::LAP_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = lap_pkg::LAP_MAX_HEIGHT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lap_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lap_pkg::CFG_DATA_W-1:0] cfg_data_i,
  lap_in_if.sink                        in_i,
  lap_out_if.source                     out_o
);
  import lap_pkg::*;

  localparam int unsigned ColW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RowW  = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned WRst  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int unsigned HRst  = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

  // configuration registers
  logic [KSEL_W-1:0]     ksel_q;
  logic [SIZE_CFG_W-1:0] cfg_w_q;
  logic [SIZE_CFG_W-1:0] cfg_h_q;
  logic [PIX_W-1:0]      max_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksel_q      <= '0;
      cfg_w_q     <= SIZE_CFG_W'(1024);
      cfg_h_q     <= SIZE_CFG_W'(1024);
      max_level_q <= PIX_W'(255);
    end else if (cfg_we_i) begin
      unique case (lap_reg_e'(cfg_idx_i))
        REG_KERNEL_SELECT: ksel_q      <= cfg_data_i[KSEL_W-1:0];
        REG_IMAGE_WIDTH:   cfg_w_q     <= cfg_data_i[SIZE_CFG_W-1:0];
        REG_IMAGE_HEIGHT:  cfg_h_q     <= cfg_data_i[SIZE_CFG_W-1:0];
        REG_MAX_LEVEL:     max_level_q <= cfg_data_i[PIX_W-1:0];
        default:           ;
      endcase
    end
  end

  // size limiting
  logic [31:0]   cfg_w_wide;
  logic [31:0]   cfg_h_wide;
  logic [WW-1:0] lim_w;
  logic [RowW-1:0] lim_h;

  assign cfg_w_wide = 32'(cfg_w_q);
  assign cfg_h_wide = 32'(cfg_h_q);
  assign lim_w = (cfg_w_wide == 32'd0)        ? WW'(1)
               : (cfg_w_wide > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_w_wide);
  assign lim_h = (cfg_h_wide == 32'd0)         ? RowW'(1)
               : (cfg_h_wide > 32'(MAX_HEIGHT)) ? RowW'(MAX_HEIGHT) : RowW'(cfg_h_wide);

  // pipeline advance and handshake
  logic out_valid_q;
  logic advance;
  logic in_acc;

  assign advance  = !out_valid_q || out_o.ready;
  assign in_i.ready = advance;
  assign in_acc   = in_i.valid && advance;

  // stream position and center counters
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] cr_q, cr_d;
  logic [ColW-1:0] cc_q, cc_d;
  logic [WW-1:0]   fw_q;
  logic [RowW-1:0] fh_q;
  logic            start;
  logic [WW-1:0]   w_eff;
  logic [RowW-1:0] h_eff;
  logic [WW-1:0]   col_inc;
  logic [WW-1:0]   cc_inc;
  logic            emit;
  logic            last_item;
  logic            in_frame;
  logic [RGB_W-1:0] pix;
  lap_bound_t      bound;
  logic            frame_last;

  assign start     = (row_q == '0) && (col_q == '0);
  assign w_eff     = start ? lim_w : fw_q;
  assign h_eff     = start ? lim_h : fh_q;
  assign col_inc   = WW'(col_q) + WW'(1);
  assign cc_inc    = WW'(cc_q) + WW'(1);
  assign in_frame  = row_q < h_eff;
  assign emit      = (row_q >= RowW'(2)) || ((row_q == RowW'(1)) && (col_q != '0));
  // last drain request sits at row H+1, column 0
  assign last_item = (row_q == h_eff + RowW'(1)) && (col_q == '0);
  assign pix       = (in_frame && !in_i.mode) ? {in_i.red, in_i.green, in_i.blue} : '0;

  // neighbors that fall outside the image
  assign bound.top    = (cr_q == '0);
  assign bound.bottom = (cr_q == h_eff - RowW'(1));
  assign bound.left   = (cc_q == '0);
  assign bound.right  = (cc_inc == w_eff);
  assign frame_last   = bound.bottom && bound.right;

  // next position
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    cr_d  = cr_q;
    cc_d  = cc_q;
    if (last_item) begin
      row_d = '0;
      col_d = '0;
    end else if (col_inc == w_eff) begin
      col_d = '0;
      row_d = row_q + RowW'(1);
    end else begin
      col_d = ColW'(col_inc);
    end
    if (emit) begin
      if (last_item) begin
        cr_d = '0;
        cc_d = '0;
      end else if (cc_inc == w_eff) begin
        cc_d = '0;
        cr_d = cr_q + RowW'(1);
      end else begin
        cc_d = ColW'(cc_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      cr_q  <= '0;
      cc_q  <= '0;
      fw_q  <= WW'(WRst);
      fh_q  <= RowW'(HRst);
    end else if (in_acc) begin
      row_q <= row_d;
      col_q <= col_d;
      cr_q  <= cr_d;
      cc_q  <= cc_d;
      if (start) begin
        fw_q <= lim_w;
        fh_q <= lim_h;
      end
    end
  end

  // input stage
  logic             s1_valid_q;
  logic             s1_emit_q;
  logic             s1_last_q;
  lap_bound_t       s1_bound_q;
  logic [RGB_W-1:0] s1_pix_q;
  logic [ColW-1:0]  s1_col_q;
  logic             byp_hit_q;
  logic [2*RGB_W-1:0] byp_data_q;
  logic [2*RGB_W-1:0] ram_rdata;
  logic [2*RGB_W-1:0] line_rd;
  logic [2*RGB_W-1:0] line_wr;
  logic             line_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_emit_q  <= emit;
      s1_last_q  <= frame_last;
      s1_bound_q <= bound;
      s1_pix_q   <= pix;
      s1_col_q   <= col_q;
      byp_hit_q  <= line_we && (s1_col_q == col_q);
      byp_data_q <= line_wr;
    end
  end

  // line stores: upper half two rows back, lower half one row back
  assign line_rd = byp_hit_q ? byp_data_q : ram_rdata;
  assign line_wr = {line_rd[RGB_W-1:0], s1_pix_q};
  assign line_we = advance && s1_valid_q;

  lap_ram #(
    .WIDTH (2 * RGB_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (s1_col_q),
    .wdata_i (line_wr),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  // 3x3 window: two stored columns plus the incoming one
  lap_col_t win_l_q;
  lap_col_t win_c_q;
  lap_col_t win_r;

  assign win_r.top = line_rd[2*RGB_W-1:RGB_W];
  assign win_r.mid = line_rd[RGB_W-1:0];
  assign win_r.bot = s1_pix_q;

  always_ff @(posedge clk_i) begin
    if (line_we) begin
      win_l_q <= win_c_q;
      win_c_q <= win_r;
    end
  end

  // per-channel convolution
  logic [PIX_W-1:0] level [3];

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    localparam int unsigned Lsb = (2 - ch) * PIX_W;
    logic [PIX_W-1:0] taps [9];

    assign taps[0] = win_l_q.top[Lsb +: PIX_W];
    assign taps[1] = win_c_q.top[Lsb +: PIX_W];
    assign taps[2] = win_r.top[Lsb +: PIX_W];
    assign taps[3] = win_l_q.mid[Lsb +: PIX_W];
    assign taps[4] = win_c_q.mid[Lsb +: PIX_W];
    assign taps[5] = win_r.mid[Lsb +: PIX_W];
    assign taps[6] = win_l_q.bot[Lsb +: PIX_W];
    assign taps[7] = win_c_q.bot[Lsb +: PIX_W];
    assign taps[8] = win_r.bot[Lsb +: PIX_W];

    lap_conv u_conv (
      .taps_i      (taps),
      .bound_i     (s1_bound_q),
      .ksel_i      (ksel_q),
      .max_level_i (max_level_q),
      .level_o     (level[ch])
    );
  end

  // result register
  logic [PIX_W-1:0] out_red_q;
  logic [PIX_W-1:0] out_green_q;
  logic [PIX_W-1:0] out_blue_q;
  logic             out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_we && s1_emit_q) begin
      out_red_q   <= level[0];
      out_green_q <= level[1];
      out_blue_q  <= level[2];
      out_last_q  <= s1_last_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_red    = out_red_q;
  assign out_o.out_green  = out_green_q;
  assign out_o.out_blue   = out_blue_q;
  assign out_o.frame_last = out_last_q;

  // checks
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_item) |=> (row_q == '0 && col_q == '0))
    else $error("position counters did not restart after the frame's last request");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start |-> (WW'(col_q) < fw_q))
    else $error("column counter beyond frame width");

  a_center_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cr_q < fh_q) && (WW'(cc_q) < fw_q))
    else $error("center counters outside the frame");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_emit_q))
    else $error("result appeared without an emitting request");

endmodule

[dv/lap_filter_checker.sv]
// ---------------------------------------------------------------------------
// lap_filter_checker
// Watches the pixel, result and configuration ports of the Laplacian filter,
// predicts each filtered pixel from its own line history and compares every
// delivered result, field by field, against the oldest prediction.
// ---------------------------------------------------------------------------
module lap_filter_checker #(
  parameter int unsigned MAX_W = lap_pkg::LAP_MAX_WIDTH,
  parameter int unsigned MAX_H = lap_pkg::LAP_MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lap_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lap_pkg::CFG_DATA_W-1:0] cfg_data_i,
  lap_in_if                              pix_i,
  lap_out_if                             res_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o
);
  import lap_pkg::*;

  // two full rows plus a little slack, indexed by frame position
  localparam int unsigned HIST_DEPTH = 2 * MAX_W + 4;

  // channel 0 red, 1 green, 2 blue
  typedef logic [2:0][PIX_W-1:0] rgb_t;

  typedef struct packed {
    rgb_t chan;
    logic frame_last;
  } filt_px_t;

  rgb_t                  pix_hist [HIST_DEPTH];
  int unsigned           row_pos;
  int unsigned           col_pos;
  int unsigned           frame_w;
  int unsigned           frame_h;
  logic [KSEL_W-1:0]     ksel_reg;
  logic [SIZE_CFG_W-1:0] width_reg;
  logic [SIZE_CFG_W-1:0] height_reg;
  logic [PIX_W-1:0]      level_reg;
  filt_px_t              filtered_q [$];

  // zero counts as one, oversize saturates
  function automatic int unsigned clip_size(input logic [SIZE_CFG_W-1:0] v,
                                            input int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // tap weight at (dr,dc), center at (1,1); bit 1 picks eight-neighbor, bit 0 negates
  function automatic int tap_weight(input logic [KSEL_W-1:0] ksel, input int dr,
                                    input int dc);
    int w;
    if (dr == 1 && dc == 1) w = ksel[1] ? 8 : 4;
    else if (ksel[1] || dr == 1 || dc == 1) w = -1;
    else w = 0;
    return ksel[0] ? -w : w;
  endfunction

  // advance one stream position, filter the center that completes here
  task automatic take_request(input logic mode, input rgb_t px, output bit produced,
                              output filt_px_t res);
    int unsigned npix, pos, ctr, r, c, q, ch, dr, dc;
    int sum;
    produced = 1'b0;
    res = '0;
    if (row_pos == 0 && col_pos == 0) begin
      frame_w = clip_size(width_reg, MAX_W);
      frame_h = clip_size(height_reg, MAX_H);
    end
    npix = frame_w * frame_h;
    pos  = row_pos * frame_w + col_pos;
    // position alone says pixel or drain; drain slots hold zero
    pix_hist[pos % HIST_DEPTH] = (pos < npix && !mode) ? px : '0;
    if (pos >= frame_w + 1) begin
      ctr = pos - frame_w - 1;
      r   = ctr / frame_w;
      c   = ctr % frame_w;
      for (ch = 0; ch < 3; ch++) begin
        sum = 0;
        for (dr = 0; dr < 3; dr++) begin
          for (dc = 0; dc < 3; dc++) begin
            // neighbors outside the image are skipped
            if ((dr == 0 && r == 0) || (dr == 2 && r + 1 >= frame_h) ||
                (dc == 0 && c == 0) || (dc == 2 && c + 1 >= frame_w)) continue;
            q = ctr + dr * frame_w + dc - frame_w - 1;
            sum += tap_weight(ksel_reg, dr, dc) * int'(pix_hist[q % HIST_DEPTH][ch]);
          end
        end
        if (sum < 0) sum = 0;
        if (sum > int'(level_reg)) sum = int'(level_reg);
        res.chan[ch] = sum[PIX_W-1:0];
      end
      res.frame_last = (ctr == npix - 1);
      produced = 1'b1;
    end
    // restart after the last drain position
    if (pos >= npix + frame_w) begin
      row_pos = 0;
      col_pos = 0;
    end else begin
      col_pos++;
      if (col_pos >= frame_w) begin
        col_pos = 0;
        row_pos++;
      end
    end
  endtask

  // watch the ports on every rising edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    filt_px_t res;
    filt_px_t want;
    rgb_t     got;
    bit       produced;
    if (!rst_ni) begin
      filtered_q.delete();
      row_pos      = 0;
      col_pos      = 0;
      ksel_reg     = '0;
      width_reg    = 11'd1024;
      height_reg   = 11'd1024;
      level_reg    = 8'd255;
      frame_w      = 1024;
      frame_h      = 1024;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // delivered result against the oldest prediction
      if (res_i.valid && res_i.ready) begin
        if (filtered_q.size() == 0) begin
          $error("result with no pending prediction");
          fail_count_o++;
        end else begin
          want = filtered_q.pop_front();
          got  = {res_i.out_blue, res_i.out_green, res_i.out_red};
          for (int ch = 0; ch < 3; ch++) begin
            if (got[ch] !== want.chan[ch]) begin
              $error("%s mismatch: expected %0d, actual %0d",
                     (ch == 0) ? "out_red" : (ch == 1) ? "out_green" : "out_blue",
                     want.chan[ch], got[ch]);
              fail_count_o++;
            end
          end
          if (res_i.frame_last !== want.frame_last) begin
            $error("frame_last mismatch: expected %0d, actual %0d",
                   want.frame_last, res_i.frame_last);
            fail_count_o++;
          end
        end
      end
      // register writes
      if (cfg_we_i) begin
        case (lap_reg_e'(cfg_idx_i))
          REG_KERNEL_SELECT: ksel_reg   = cfg_data_i[KSEL_W-1:0];
          REG_IMAGE_WIDTH:   width_reg  = cfg_data_i[SIZE_CFG_W-1:0];
          REG_IMAGE_HEIGHT:  height_reg = cfg_data_i[SIZE_CFG_W-1:0];
          REG_MAX_LEVEL:     level_reg  = cfg_data_i[PIX_W-1:0];
          default: ;
        endcase
      end
      // accepted pixel request
      if (pix_i.valid && pix_i.ready) begin
        take_request(pix_i.mode, {pix_i.blue, pix_i.green, pix_i.red}, produced, res);
        if (produced) filtered_q.push_back(res);
      end
      pending_o = filtered_q.size();
    end
  end

endmodule

[dv/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Drives raster frames through the 3x3 Laplacian filter: a short directed
// pass over kernels, sample extremes and item type corner cases, then random
// frames with changing sizes, kernels and clamp levels, random gaps on both
// channels and one long result stall.
// ---------------------------------------------------------------------------
module tb;
  import lap_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 720;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned SETTLE       = 4;
  localparam int unsigned TAIL         = 8;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           fail_count;
  int unsigned           pending;

  bit                    tx_calm;
  bit                    rx_calm;
  int unsigned           hold_tokens;
  int unsigned           holds_done;
  int unsigned           random_sent;
  int unsigned           nxt_w;
  int unsigned           nxt_h;
  int unsigned           owed;

  lap_in_if  in_ch ();
  lap_out_if out_ch ();

  laplacian_filter_3x3 DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  lap_filter_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pix_i        (in_ch),
    .res_i        (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PIX_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 24) return '1;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  function automatic int unsigned pick_width();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 10) return 1;
    if (r < 75) return $urandom_range(2, 6);
    return $urandom_range(7, 16);
  endfunction

  function automatic int unsigned pick_height();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 15) return 1;
    if (r < 80) return $urandom_range(2, 5);
    return $urandom_range(6, 9);
  endfunction

  function automatic int unsigned pick_level();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 15) return 1;
    if (r < 45) return 255;
    return $urandom_range(0, 255);
  endfunction

  // frame size as the block will latch it
  function automatic int unsigned eff_size(input int unsigned v, input int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // offer one pixel request after an optional gap, return once accepted
  task automatic push_request(input logic mode, input logic [PIX_W-1:0] r,
                              input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b);
    int unsigned gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.mode  <= mode;
    in_ch.red   <= r;
    in_ch.green <= g;
    in_ch.blue  <= b;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // stop sending and wait until every predicted result has come out
  task automatic drain_pipe();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input lap_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic reprogram(input int unsigned ksel, input int unsigned w,
                           input int unsigned h, input int unsigned lvl);
    write_reg(REG_KERNEL_SELECT, CFG_DATA_W'(ksel));
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_MAX_LEVEL, CFG_DATA_W'(lvl));
    nxt_w = eff_size(w % 2048, LAP_MAX_WIDTH);
    nxt_h = eff_size(h % 2048, LAP_MAX_HEIGHT);
  endtask

  // one frame: leftover drain slots of a short previous frame, pixels, drains
  task automatic send_frame(input bit mid_write);
    int unsigned cur_w, cur_h, lead, npix, drains, cut, total, mid_at, i;
    logic m;
    cur_w  = nxt_w;
    cur_h  = nxt_h;
    lead   = owed;
    owed   = 0;
    npix   = cur_w * cur_h;
    drains = cur_w + 1;
    // short drain: the next frame first fills the missing drain slots
    if ($urandom_range(0, 19) == 0) begin
      cut    = $urandom_range(1, 2);
      drains = drains - cut;
      owed   = cut;
    end
    total  = lead + npix + drains;
    mid_at = mid_write ? $urandom_range(lead + 1, total - 1) : total;
    for (i = 0; i < total; i++) begin
      // writes inside a frame: sizes wait for the next frame
      if (i == mid_at) begin
        drain_pipe();
        reprogram($urandom_range(0, 3), pick_width(), pick_height(), pick_level());
      end
      if (i < lead) m = 1'b0;
      else if (i < lead + npix) m = ($urandom_range(0, 19) == 0);
      else m = ($urandom_range(0, 9) != 0);
      push_request(m, pick_sample(), pick_sample(), pick_sample());
      random_sent++;
    end
  endtask

  // result side: random stalls, plus a long hold when one is requested
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && holds_done != hold_tokens) begin
        holds_done++;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // watchdog on cycles with no request moving on either channel
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int unsigned i;
    int unsigned frame_idx;
    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = REG_KERNEL_SELECT;
    cfg_data    = '0;
    in_ch.valid = 1'b0;
    in_ch.mode  = 1'b0;
    in_ch.red   = '0;
    in_ch.green = '0;
    in_ch.blue  = '0;
    tx_calm     = 1'b0;
    rx_calm     = 1'b0;
    hold_tokens = 0;
    holds_done  = 0;
    random_sent = 0;
    owed        = 0;
    nxt_w       = LAP_MAX_WIDTH;
    nxt_h       = LAP_MAX_HEIGHT;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // 3x3 frame with kernel and clamp left at their reset values
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
    for (i = 0; i < 9; i++) begin
      push_request(1'b0, i[0] ? 8'd0 : 8'd255, i[0] ? 8'd255 : 8'd0,
                   (i == 4) ? 8'd255 : 8'd0);
    end
    repeat (4) push_request(1'b1, 8'd0, 8'd0, 8'd0);

    // center -8: drain inside the pixel phase, pixel inside the drain phase
    drain_pipe();
    reprogram(3, 2, 2, 255);
    push_request(1'b0, 8'd255, 8'd255, 8'd255);
    push_request(1'b1, 8'd255, 8'd255, 8'd255);
    push_request(1'b0, 8'd0, 8'd128, 8'd255);
    push_request(1'b0, 8'd255, 8'd0, 8'd0);
    push_request(1'b0, 8'd255, 8'd255, 8'd255);
    push_request(1'b1, 8'd0, 8'd0, 8'd0);
    push_request(1'b1, 8'd0, 8'd0, 8'd0);

    // zero sizes behave as one, clamp level zero
    drain_pipe();
    reprogram(2, 0, 0, 0);
    push_request(1'b0, 8'd255, 8'd255, 8'd255);
    push_request(1'b1, 8'd0, 8'd0, 8'd0);
    push_request(1'b1, 8'd0, 8'd0, 8'd0);

    // center -4, single column, clamp level one
    drain_pipe();
    reprogram(1, 1, 2, 1);
    push_request(1'b0, 8'd0, 8'd0, 8'd0);
    push_request(1'b0, 8'd255, 8'd255, 8'd255);
    push_request(1'b1, 8'd0, 8'd0, 8'd0);
    push_request(1'b1, 8'd0, 8'd0, 8'd0);

    // random frames
    frame_idx = 0;
    while (random_sent < RANDOM_ITEMS) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (frame_idx == 4) begin
        // long result stall while requests keep coming
        drain_pipe();
        reprogram($urandom_range(0, 3), 12, 6, 255);
        tx_calm = 1'b1;
        hold_tokens++;
      end else if (frame_idx == 0 || $urandom_range(0, 2) == 0) begin
        drain_pipe();
        reprogram($urandom_range(0, 3), pick_width(), pick_height(), pick_level());
      end
      send_frame(frame_idx != 4 && $urandom_range(0, 6) == 0);
      frame_idx++;
    end

    drain_pipe();
    repeat (TAIL) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[laplacian_filter_3x3.f]
rtl/lap_pkg.sv
rtl/lap_in_if.sv
rtl/lap_out_if.sv
rtl/lap_ram.sv
rtl/lap_conv.sv
rtl/laplacian_filter_3x3.sv
dv/lap_filter_checker.sv
dv/tb.sv
